// ===== src/slac_pkg.sv =====
// Shared constants and types for the set-associative LRU cache model.
// No dependencies; imported by every module of the block but slac_ram.
`default_nettype none

package slac_pkg;

    localparam int MAX_SET_BITS_DEF = 6;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int ADDR_BITS_DEF    = 32;

    localparam int OP_W         = 2;
    localparam int ADDR_W       = 32;
    localparam int CNT_W        = 32;
    localparam int STAMP_W      = 32;
    localparam int SHAMT_W      = 6;
    localparam int SET_BITS_W   = 3;
    localparam int BLOCK_BITS_W = 5;
    localparam int WAYS_W       = 4;
    localparam int APB_AW       = 4;
    localparam int APB_DW       = 32;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
    localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] REG_SET_BITS   = 2'd0;
    localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
    localparam logic [1:0] REG_WAYS       = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOOK = 2'b10
    } t_state;

endpackage

`default_nettype wire

// ===== src/slac_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module slac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/slac_way_sel.sv =====
// Way selection for one set: tag match, first free way, and LRU victim.
// Depends on slac_pkg for the stamp width.
`default_nettype none

module slac_way_sel
    import slac_pkg::*;
#(
    parameter int MAX_WAYS = MAX_WAYS_DEF,
    parameter int TAG_W    = ADDR_BITS_DEF
) (
    input  wire logic [MAX_WAYS-1:0]              i_use,
    input  wire logic [MAX_WAYS-1:0]              i_vld,
    input  wire logic [MAX_WAYS-1:0][TAG_W-1:0]   i_tag_row,
    input  wire logic [MAX_WAYS-1:0][STAMP_W-1:0] i_stamp_row,
    input  wire logic [TAG_W-1:0]                 i_tag,
    output logic                                  o_hit,
    output logic                                  o_evict,
    output logic      [MAX_WAYS-1:0]              o_way_oh
);

    logic [MAX_WAYS-1:0] match;
    logic [MAX_WAYS-1:0] free;
    logic [MAX_WAYS-1:0] is_min;
    logic [MAX_WAYS-1:0] match_oh;
    logic [MAX_WAYS-1:0] free_oh;
    logic [MAX_WAYS-1:0] min_oh;

    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            match[i]  = i_use[i] & i_vld[i] & (i_tag_row[i] == i_tag);
            free[i]   = i_use[i] & ~i_vld[i];
            is_min[i] = i_use[i];
            for (int j = 0; j < MAX_WAYS; j++) begin
                if (i_use[j] && (i_stamp_row[j] < i_stamp_row[i])) begin
                    is_min[i] = 1'b0;
                end
            end
        end
    end

    // lowest set bit of each candidate vector
    assign match_oh = match & (~match + MAX_WAYS'(1));
    assign free_oh  = free & (~free + MAX_WAYS'(1));
    assign min_oh   = is_min & (~is_min + MAX_WAYS'(1));

    always_comb begin
        o_hit   = |match;
        o_evict = ~(|match) & ~(|free);
        if (|match) begin
            o_way_oh = match_oh;
        end else if (|free) begin
            o_way_oh = free_oh;
        end else begin
            o_way_oh = min_oh;
        end
    end

endmodule

`default_nettype wire

// ===== src/set_assoc_lru_cache_model.sv =====
// Set-associative cache model with true LRU replacement; top level.
// Result: registered in r_out_valid after the access beat is accepted and the
// set row is read and looked up in S_LOOK. Flow: one access at a time; a new
// access is taken only in S_IDLE, after the row write-back, and not while a
// result is stalled. Reset: clears state, configuration registers, counters,
// access stamp and per-set valid flags; no clearing pass. Depends on slac_pkg, slac_ram, slac_way_sel.
`default_nettype none

module set_assoc_lru_cache_model
    import slac_pkg::*;
#(
    parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = MAX_WAYS_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [ADDR_W-1:0] i_address,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_first_hit,
    output logic                   o_evicted,
    output logic                   o_second_hit,
    output logic      [CNT_W-1:0]  o_hit_total,
    output logic      [CNT_W-1:0]  o_miss_total,
    output logic      [CNT_W-1:0]  o_eviction_total
);

    localparam int SETS  = 2 ** MAX_SET_BITS;
    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int TAG_W = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int ROW_W = MAX_WAYS * (1 + TAG_W + STAMP_W);

    t_state r_state;

    logic [SET_BITS_W-1:0]   r_set_bits;
    logic [BLOCK_BITS_W-1:0] r_block_bits;
    logic [WAYS_W-1:0]       r_ways;

    logic [OP_W-1:0]    r_op;
    logic [SET_W-1:0]   r_set;
    logic [TAG_W-1:0]   r_tag;
    logic [SETS-1:0]    r_row_vld;
    logic [STAMP_W-1:0] r_access_stamp;
    logic [CNT_W-1:0]   r_hit_cnt;
    logic [CNT_W-1:0]   r_miss_cnt;
    logic [CNT_W-1:0]   r_evict_cnt;
    logic               r_out_valid;
    logic               r_first_hit;
    logic               r_evicted;
    logic               r_second_hit;

    logic               in_acc;
    logic               cfg_wr;
    logic [TAG_W-1:0]   addr_m;
    logic [TAG_W-1:0]   addr_sh;
    logic [SHAMT_W-1:0] s_eff;
    logic [SHAMT_W-1:0] shamt;
    logic [SET_W-1:0]   n_set;
    logic [TAG_W-1:0]   n_tag;

    logic [ROW_W-1:0]                     rd_row;
    logic [ROW_W-1:0]                     wr_row;
    logic [MAX_WAYS-1:0]                  rd_vld_raw;
    logic [MAX_WAYS-1:0]                  rd_vld;
    logic [MAX_WAYS-1:0][TAG_W-1:0]       rd_tag;
    logic [MAX_WAYS-1:0][STAMP_W-1:0]     rd_stamp;
    logic [MAX_WAYS-1:0]                  wr_vld;
    logic [MAX_WAYS-1:0][TAG_W-1:0]       wr_tag;
    logic [MAX_WAYS-1:0][STAMP_W-1:0]     wr_stamp;
    logic [MAX_WAYS-1:0]                  use_mask;
    logic [MAX_WAYS-1:0]                  way_oh;
    logic                                 sel_hit;
    logic                                 sel_evict;

    logic               acc;
    logic               is_mod;
    logic               wb_en;
    logic [STAMP_W-1:0] n_stamp;
    logic [1:0]         hit_inc;
    logic [CNT_W:0]     hit_sum;
    logic [CNT_W:0]     miss_sum;
    logic [CNT_W:0]     evict_sum;
    logic [CNT_W-1:0]   n_hit_cnt;
    logic [CNT_W-1:0]   n_miss_cnt;
    logic [CNT_W-1:0]   n_evict_cnt;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb begin
        unique case (paddr[3:2])
            REG_SET_BITS:   prdata = APB_DW'(r_set_bits);
            REG_BLOCK_BITS: prdata = APB_DW'(r_block_bits);
            REG_WAYS:       prdata = APB_DW'(r_ways);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= '0;
            r_block_bits <= '0;
            r_ways       <= WAYS_W'(1);
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_SET_BITS:   r_set_bits   <= pwdata[SET_BITS_W-1:0];
                REG_BLOCK_BITS: r_block_bits <= pwdata[BLOCK_BITS_W-1:0];
                REG_WAYS:       r_ways       <= pwdata[WAYS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // address split
    assign in_acc = i_in_valid & o_in_ready;
    assign addr_m = i_address[TAG_W-1:0];

    always_comb begin
        if (int'(r_set_bits) > MAX_SET_BITS) begin
            s_eff = SHAMT_W'(MAX_SET_BITS);
        end else begin
            s_eff = SHAMT_W'(r_set_bits);
        end
        shamt   = s_eff + SHAMT_W'(r_block_bits);
        addr_sh = addr_m >> r_block_bits;
        n_set   = addr_sh[SET_W-1:0] & ~({SET_W{1'b1}} << s_eff);
        n_tag   = addr_m >> shamt;
    end

    // set memory: one row holds valid bits, tags and stamps of all ways
    slac_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wb_en),
        .i_waddr (r_set),
        .i_wdata (wr_row),
        .i_re    (in_acc),
        .i_raddr (n_set),
        .o_rdata (rd_row)
    );

    assign {rd_vld_raw, rd_tag, rd_stamp} = rd_row;
    assign rd_vld = rd_vld_raw & {MAX_WAYS{r_row_vld[r_set]}};

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            use_mask[w] = (w == 0) || (int'(r_ways) > w);
        end
    end

    slac_way_sel #(
        .MAX_WAYS (MAX_WAYS),
        .TAG_W    (TAG_W)
    ) u_way_sel (
        .i_use       (use_mask),
        .i_vld       (rd_vld),
        .i_tag_row   (rd_tag),
        .i_stamp_row (rd_stamp),
        .i_tag       (r_tag),
        .o_hit       (sel_hit),
        .o_evict     (sel_evict),
        .o_way_oh    (way_oh)
    );

    // write-back row and counter update
    assign acc     = (r_op == OP_LOAD) || (r_op == OP_STORE) || (r_op == OP_MODIFY);
    assign is_mod  = (r_op == OP_MODIFY);
    assign wb_en   = (r_state == S_LOOK) && acc;
    assign n_stamp = r_access_stamp + STAMP_W'(1);

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            wr_vld[w]   = rd_vld[w] | way_oh[w];
            wr_tag[w]   = way_oh[w] ? r_tag : rd_tag[w];
            wr_stamp[w] = way_oh[w] ? n_stamp : rd_stamp[w];
        end
    end

    assign wr_row = {wr_vld, wr_tag, wr_stamp};

    always_comb begin
        hit_inc     = {1'b0, acc & sel_hit} + {1'b0, is_mod};
        hit_sum     = {1'b0, r_hit_cnt} + (CNT_W + 1)'(hit_inc);
        miss_sum    = {1'b0, r_miss_cnt} + (CNT_W + 1)'(acc & ~sel_hit);
        evict_sum   = {1'b0, r_evict_cnt} + (CNT_W + 1)'(acc & sel_evict);
        n_hit_cnt   = hit_sum[CNT_W] ? '1 : hit_sum[CNT_W-1:0];
        n_miss_cnt  = miss_sum[CNT_W] ? '1 : miss_sum[CNT_W-1:0];
        n_evict_cnt = evict_sum[CNT_W] ? '1 : evict_sum[CNT_W-1:0];
    end

    // control
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_row_vld      <= '0;
            r_access_stamp <= '0;
            r_hit_cnt      <= '0;
            r_miss_cnt     <= '0;
            r_evict_cnt    <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b1;
                    r_hit_cnt   <= n_hit_cnt;
                    r_miss_cnt  <= n_miss_cnt;
                    r_evict_cnt <= n_evict_cnt;
                    if (acc) begin
                        r_access_stamp   <= n_stamp;
                        r_row_vld[r_set] <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op  <= i_op;
            r_set <= n_set;
            r_tag <= n_tag;
        end
        if (r_state == S_LOOK) begin
            r_first_hit  <= acc & sel_hit;
            r_evicted    <= acc & sel_evict;
            r_second_hit <= is_mod;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_first_hit      = r_first_hit;
    assign o_evicted        = r_evicted;
    assign o_second_hit     = r_second_hit;
    assign o_hit_total      = r_hit_cnt;
    assign o_miss_total     = r_miss_cnt;
    assign o_eviction_total = r_evict_cnt;

endmodule

`default_nettype wire

// ===== src/slac_chk.sv =====
// Port-level checker for the set-associative LRU cache model, bound to the top.
// Depends on slac_pkg and set_assoc_lru_cache_model.
`default_nettype none

module slac_chk
    import slac_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_ready,
    input wire logic             o_out_valid,
    input wire logic             i_out_ready,
    input wire logic             o_first_hit,
    input wire logic             o_evicted,
    input wire logic [CNT_W-1:0] o_hit_total
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_hit_total))
        else $error("result beat dropped or changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second access taken while one is in flight");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |-> ##2 o_out_valid)
        else $error("result not presented two cycles after access");

    a_evict_is_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_evicted && o_first_hit))
        else $error("eviction reported on a hit");

    a_hits_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> o_hit_total >= $past(o_hit_total))
        else $error("hit total decreased");

endmodule

bind set_assoc_lru_cache_model slac_chk u_slac_chk (.*);

`default_nettype wire

// ===== dv/tb_set_assoc_lru_cache_model.sv =====
`timescale 1ns / 100ps
// Testbench for set_assoc_lru_cache_model: directed and random access streams
// checked beat by beat against a built-in LRU cache predictor.
// Depends on slac_pkg and the set_assoc_lru_cache_model RTL.

module tb_set_assoc_lru_cache_model;
    import slac_pkg::*;

    localparam int NUM_LINES   = (1 << MAX_SET_BITS_DEF) * MAX_WAYS_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RX_HOLD     = 300;
    localparam int PHASE_ITEMS = 220;

    typedef struct {
        bit              first_hit;
        bit              evicted;
        bit              second_hit;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] evictions;
    } t_cache_outcome;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [OP_W-1:0]   i_op;
    logic [ADDR_W-1:0] i_address;
    logic              o_out_valid;
    logic              i_out_ready;
    logic              o_first_hit;
    logic              o_evicted;
    logic              o_second_hit;
    logic [CNT_W-1:0]  o_hit_total;
    logic [CNT_W-1:0]  o_miss_total;
    logic [CNT_W-1:0]  o_eviction_total;

    // predictor state
    logic [SET_BITS_W-1:0]   cfg_set_bits;
    logic [BLOCK_BITS_W-1:0] cfg_block_bits;
    logic [WAYS_W-1:0]       cfg_ways;
    bit                      line_ok   [NUM_LINES];
    logic [ADDR_W-1:0]       line_key  [NUM_LINES];
    logic [STAMP_W-1:0]      line_age  [NUM_LINES];
    logic [STAMP_W-1:0]      use_stamp;
    logic [CNT_W-1:0]        hit_cnt;
    logic [CNT_W-1:0]        miss_cnt;
    logic [CNT_W-1:0]        evict_cnt;

    t_cache_outcome pending_outcomes[$];
    int             mismatch_cnt;
    int             cycle_cnt;
    bit             tx_idle_en;
    bit             rx_idle_en;
    bit             rx_hold_req;
    int             rx_gap;

    set_assoc_lru_cache_model dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_op             (i_op),
        .i_address        (i_address),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_first_hit      (o_first_hit),
        .o_evicted        (o_evicted),
        .o_second_hit     (o_second_hit),
        .o_hit_total      (o_hit_total),
        .o_miss_total     (o_miss_total),
        .o_eviction_total (o_eviction_total)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    function automatic logic [CNT_W-1:0] sat_bump(logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic int eff_ways();
        if (cfg_ways == 0)
            return 1;
        if (cfg_ways > MAX_WAYS_DEF)
            return MAX_WAYS_DEF;
        return int'(cfg_ways);
    endfunction

    function automatic int eff_set_bits();
        return (cfg_set_bits > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : int'(cfg_set_bits);
    endfunction

    function automatic t_cache_outcome predict_access(logic [OP_W-1:0] op,
                                                      logic [ADDR_W-1:0] addr);
        t_cache_outcome r;
        int             s;
        int             ways;
        int             shift;
        int             base;
        int             victim;
        int             hit_way;
        int             free_way;
        logic [ADDR_W-1:0] key;
        r = '{default: 0};
        s = eff_set_bits();
        ways = eff_ways();
        shift = s + int'(cfg_block_bits);
        base = int'((addr >> cfg_block_bits) & ((32'd1 << s) - 1)) * MAX_WAYS_DEF;
        key = (shift >= ADDR_W) ? '0 : addr >> shift;
        if (op != OP_NONE) begin
            use_stamp = use_stamp + 1'b1;
            hit_way = -1;
            free_way = -1;
            for (int i = 0; i < ways; i++) begin
                if (hit_way < 0 && line_ok[base + i] && line_key[base + i] == key)
                    hit_way = i;
                if (free_way < 0 && !line_ok[base + i])
                    free_way = i;
            end
            if (hit_way >= 0) begin
                r.first_hit = 1'b1;
                hit_cnt = sat_bump(hit_cnt);
                line_age[base + hit_way] = use_stamp;
            end else begin
                miss_cnt = sat_bump(miss_cnt);
                if (free_way >= 0) begin
                    victim = free_way;
                    line_ok[base + victim] = 1'b1;
                end else begin
                    victim = 0;
                    for (int i = 1; i < ways; i++)
                        if (line_age[base + victim] > line_age[base + i])
                            victim = i;
                    evict_cnt = sat_bump(evict_cnt);
                    r.evicted = 1'b1;
                end
                line_key[base + victim] = key;
                line_age[base + victim] = use_stamp;
            end
            if (op == OP_MODIFY) begin
                r.second_hit = 1'b1;
                hit_cnt = sat_bump(hit_cnt);
            end
        end
        r.hits = hit_cnt;
        r.misses = miss_cnt;
        r.evictions = evict_cnt;
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) < 17)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random stalls, with a long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        rx_gap = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_gap = RX_HOLD;
                rx_hold_req = 1'b0;
            end else if (rx_gap == 0 && rx_idle_en && $urandom_range(0, 4) == 0) begin
                rx_gap = gap_len();
            end
            if (rx_gap > 0) begin
                i_out_ready <= 1'b0;
                rx_gap--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_cache_outcome e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual hit=%b miss=%0d",
                         $time, o_first_hit, o_miss_total);
                mismatch_cnt++;
            end else begin
                e = pending_outcomes.pop_front();
                check_field("first_hit", 32'(e.first_hit), 32'(o_first_hit));
                check_field("evicted", 32'(e.evicted), 32'(o_evicted));
                check_field("second_hit", 32'(e.second_hit), 32'(o_second_hit));
                check_field("hit_total", e.hits, o_hit_total);
                check_field("miss_total", e.misses, o_miss_total);
                check_field("eviction_total", e.evictions, o_eviction_total);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_outcomes.size());
            $display("tb_set_assoc_lru_cache_model failed");
            $finish;
        end
    end

    task automatic send_access(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
        int g;
        @(negedge i_clk);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            g = gap_len();
            i_in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_address <= addr;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        pending_outcomes.push_back(predict_access(op, addr));
    endtask

    // drop valid, wait for every outstanding beat, then let the pipeline empty
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SET_BITS:   cfg_set_bits = val[SET_BITS_W-1:0];
            REG_BLOCK_BITS: cfg_block_bits = val[BLOCK_BITS_W-1:0];
            REG_WAYS:       cfg_ways = val[WAYS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input int s, input int b, input int w);
        settle();
        write_reg(REG_SET_BITS, s);
        write_reg(REG_BLOCK_BITS, b);
        write_reg(REG_WAYS, w);
    endtask

    task automatic run_random_phase(input int s, input int b, input int w, input int count);
        logic [ADDR_W-1:0] tag_pool[$];
        logic [63:0]       low_mask;
        logic [ADDR_W-1:0] addr;
        logic [OP_W-1:0]   op;
        int                shift;
        int                nsets;
        int                set_idx;
        int                r;
        set_geometry(s, b, w);
        shift = eff_set_bits() + b;
        nsets = 1 << eff_set_bits();
        low_mask = (64'd1 << shift) - 1;
        for (int i = 0; i < eff_ways() + 2; i++)
            tag_pool.push_back($urandom);
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 40)
                op = OP_LOAD;
            else if (r < 65)
                op = OP_STORE;
            else if (r < 93)
                op = OP_MODIFY;
            else
                op = OP_NONE;
            if ($urandom_range(0, 9) == 0) begin
                addr = $urandom;
            end else begin
                if ($urandom_range(0, 3) == 0)
                    set_idx = $urandom_range(0, nsets - 1);
                else
                    set_idx = $urandom_range(0, (nsets < 4) ? nsets - 1 : 3);
                addr = (tag_pool[$urandom_range(0, tag_pool.size() - 1)] & ~low_mask[31:0])
                     | ((32'(set_idx) << b) & low_mask[31:0])
                     | ($urandom & ((32'd1 << b) - 1));
            end
            send_access(op, addr);
        end
    endtask

    task automatic test_directed();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        // reset geometry: one set, one way
        send_access(OP_LOAD, 32'h0000_0000);
        send_access(OP_LOAD, 32'h0000_0000);
        send_access(OP_STORE, 32'hFFFF_FFFF);
        send_access(OP_MODIFY, 32'hFFFF_FFFF);
        send_access(OP_NONE, 32'h0000_1234);
        send_access(OP_LOAD, 32'h0000_0000);
        // out-of-range set and way counts, tag wider split than the address
        set_geometry(7, 31, 15);
        send_access(OP_LOAD, 32'h0000_0000);
        send_access(OP_LOAD, 32'h7FFF_FFFF);
        send_access(OP_LOAD, 32'h8000_0000);
        send_access(OP_MODIFY, 32'hFFFF_FFFF);
        // zero ways acts as one
        set_geometry(0, 0, 0);
        send_access(OP_LOAD, 32'h0000_0005);
        send_access(OP_LOAD, 32'h0000_0006);
        send_access(OP_STORE, 32'h0000_0005);
        send_access(OP_MODIFY, 32'h0000_0006);
        // two-way LRU ordering
        set_geometry(1, 2, 2);
        send_access(OP_LOAD, 32'h0000_0008);
        send_access(OP_LOAD, 32'h0000_0010);
        send_access(OP_LOAD, 32'h0000_0008);
        send_access(OP_LOAD, 32'h0000_0018);
        send_access(OP_LOAD, 32'h0000_0010);
        send_access(OP_LOAD, 32'h0000_0018);
        settle();
    endtask

    task automatic test_random_geometry();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        run_random_phase(0, 0, 1, PHASE_ITEMS);
        run_random_phase(6, 31, 8, PHASE_ITEMS);
        run_random_phase(7, 0, 15, PHASE_ITEMS);
        run_random_phase(3, 4, 4, PHASE_ITEMS);
        run_random_phase(2, 5, 0, PHASE_ITEMS);
        run_random_phase($urandom_range(0, 7), $urandom_range(0, 31), $urandom_range(0, 15),
                         PHASE_ITEMS);
        run_random_phase($urandom_range(0, 7), $urandom_range(0, 8), $urandom_range(1, 15),
                         PHASE_ITEMS);
        settle();
    endtask

    task automatic test_back_to_back();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_random_phase(4, 2, 8, 120);
        settle();
    endtask

    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b1;
        set_geometry(1, 3, 3);
        rx_hold_req = 1'b1;
        run_random_phase(1, 3, 3, 60);
        settle();
    endtask

    initial begin
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_in_valid = 1'b0;
        i_op = OP_LOAD;
        i_address = '0;
        mismatch_cnt = 0;
        cycle_cnt = 0;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        rx_hold_req = 1'b0;
        cfg_set_bits = '0;
        cfg_block_bits = '0;
        cfg_ways = 4'd1;
        use_stamp = '0;
        hit_cnt = '0;
        miss_cnt = '0;
        evict_cnt = '0;
        for (int i = 0; i < NUM_LINES; i++) begin
            line_ok[i] = 1'b0;
            line_key[i] = '0;
            line_age[i] = '0;
        end
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_geometry();
        test_back_to_back();
        test_backpressure();

        repeat (10) @(posedge i_clk);
        if (pending_outcomes.size() != 0)
            mismatch_cnt++;
        if (mismatch_cnt == 0) begin
            $display("tb_set_assoc_lru_cache_model passed");
        end else begin
            $display("tb_set_assoc_lru_cache_model failed");
        end
        $finish;
    end

endmodule
